>>> rtl/core/lrbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LRU register binding table.
package lrbt_pkg;

  // Widths of the port fields.
  localparam int FUNC_W     = 2;
  localparam int KEY_PORT_W = 16;
  localparam int CLASS_W    = 2;
  localparam int INDEX_W    = 3;
  localparam int CFG_W      = 8;

  // Only the first input slots can be reserved by the mask register.
  localparam int RESERVED_SLOTS = 8;
  localparam logic [CFG_W-1:0] RESERVED_MASK_RESET = 8'd192;

  // Function codes of an input word.
  localparam logic [FUNC_W-1:0] FUNC_ACCESS = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  // Register class codes of a result word.
  localparam logic [CLASS_W-1:0] CLASS_LOCAL = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_INPUT = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd2;

  // Status codes of a result word.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Search flags that ripple along the row of cells.
  typedef struct packed {
    logic lhit;
    logic ihit;
    logic lfree;
    logic ifree;
    logic victim;
  } lrbt_find_t;

  // Update command broadcast from the controller to every cell.
  typedef struct packed {
    logic touch_hit;
    logic touch_victim;
    logic fill_local;
    logic fill_input;
    logic flush_clear;
    logic tok_run;
  } lrbt_cmd_t;

endpackage

>>> rtl/core/lrbt_cell.sv
`timescale 1ns / 1ps
// One slot of the table: a local entry with its LRU rank and an input entry.
module lrbt_cell #(
  parameter int KEY_W       = 16,
  parameter int RANK_W      = 3,
  parameter int OLDEST_RANK = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lrbt_pkg::lrbt_cmd_t     cmd_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [RANK_W-1:0]       ref_rank_i,
  input  logic                    reserved_i,
  input  lrbt_pkg::lrbt_find_t    seen_i,
  output lrbt_pkg::lrbt_find_t    seen_o,
  output lrbt_pkg::lrbt_find_t    sel_o,
  input  logic                    tok_i,
  output logic                    tok_o,
  output logic                    lvalid_o,
  output logic [KEY_W-1:0]        lkey_o,
  output logic [RANK_W-1:0]       lrank_o
);
  import lrbt_pkg::*;

  localparam logic [RANK_W-1:0] OLDEST = RANK_W'(OLDEST_RANK);

  logic [KEY_W-1:0]  lkey_r, lkey_nxt;
  logic              lvalid_r, lvalid_nxt;
  logic [RANK_W-1:0] lrank_r, lrank_nxt;
  logic [KEY_W-1:0]  ikey_r, ikey_nxt;
  logic              ivalid_r, ivalid_nxt;
  logic              tok_r, tok_nxt;
  lrbt_find_t        mine;
  logic              touched;
  logic              filled;

  // What this slot offers to the search.
  always_comb begin
    mine.lhit   = lvalid_r & (lkey_r == key_i);
    mine.ihit   = ivalid_r & ~reserved_i & (ikey_r == key_i);
    mine.lfree  = ~lvalid_r;
    mine.ifree  = ~ivalid_r & ~reserved_i;
    mine.victim = lvalid_r & (lrank_r == OLDEST);
  end

  // A slot is chosen only if no lower slot already claimed the same flag.
  assign seen_o = lrbt_find_t'(seen_i | mine);
  assign sel_o  = lrbt_find_t'(mine & ~seen_i);

  assign touched = (cmd_i.touch_hit & sel_o.lhit) | (cmd_i.touch_victim & sel_o.victim);
  assign filled  = cmd_i.fill_local & sel_o.lfree;

  always_comb begin
    lkey_nxt   = lkey_r;
    lvalid_nxt = lvalid_r;
    lrank_nxt  = lrank_r;
    ikey_nxt   = ikey_r;
    ivalid_nxt = ivalid_r;
    if (cmd_i.flush_clear) begin
      lvalid_nxt = 1'b0;
      lrank_nxt  = '0;
    end else if (touched) begin
      lrank_nxt = '0;
      if (cmd_i.touch_victim) begin
        lkey_nxt = key_i;
      end
    end else if (filled) begin
      lkey_nxt   = key_i;
      lvalid_nxt = 1'b1;
      lrank_nxt  = '0;
    end else if ((cmd_i.touch_hit | cmd_i.touch_victim) & lvalid_r &
                 (lrank_r < ref_rank_i)) begin
      lrank_nxt = lrank_r + 1'b1;
    end else if (cmd_i.fill_local & lvalid_r) begin
      lrank_nxt = lrank_r + 1'b1;
    end
    if (cmd_i.fill_input & sel_o.ifree) begin
      ikey_nxt   = key_i;
      ivalid_nxt = 1'b1;
    end
    tok_nxt = cmd_i.tok_run & tok_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= 1'b0;
      lrank_r  <= '0;
      ivalid_r <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      lvalid_r <= lvalid_nxt;
      lrank_r  <= lrank_nxt;
      ivalid_r <= ivalid_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lkey_r <= lkey_nxt;
    ikey_r <= ikey_nxt;
  end

  assign tok_o    = tok_r;
  assign lvalid_o = lvalid_r;
  assign lkey_o   = lkey_r;
  assign lrank_o  = lrank_r;

endmodule

>>> rtl/core/lru_register_binding_table_core.sv
`timescale 1ns / 1ps
// Top level of the LRU register binding table: controller and row of slot cells.
// A word is taken in the idle state and decoded in the execute state; its result is registered.
// Access, bind and unused codes and an empty-table flush then return to idle; a flush of a
// non-empty table goes on in the flush state until the token reaches h, the highest valid slot,
// as the flush token walks the row one cell per cycle. Results are never stalled.
// Reset is synchronous, active low: all entries invalid, ranks zero, mask 192; no clearing pass.
module lru_register_binding_table_core #(
  parameter int ENTRY_COUNT = 8,
  parameter int KEY_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lrbt_pkg::FUNC_W-1:0]     in_func,
  input  logic [lrbt_pkg::KEY_PORT_W-1:0] in_key,
  output logic                            out_valid,
  output logic [lrbt_pkg::CLASS_W-1:0]    out_reg_class,
  output logic [lrbt_pkg::INDEX_W-1:0]    out_reg_index,
  output logic                            out_hit,
  output logic                            out_evict_valid,
  output logic [lrbt_pkg::KEY_PORT_W-1:0] out_evict_key,
  output logic                            out_status,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrbt_pkg::CFG_W-1:0]      cfg_data
);
  import lrbt_pkg::*;

  // Keys are kept to KEY_BITS bits, and never more than the port carries.
  localparam int KEY_W  = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int RANK_W = $clog2(ENTRY_COUNT);
  localparam logic [RANK_W-1:0] OLDEST = RANK_W'(ENTRY_COUNT - 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [FUNC_W-1:0]  op_func_r, op_func_nxt;
  logic [KEY_W-1:0]   op_key_r, op_key_nxt;
  logic [CFG_W-1:0]   mask_r, mask_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]    out_class_r, out_class_nxt;
  logic [INDEX_W-1:0]    out_index_r, out_index_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_ev_r, out_ev_nxt;
  logic [KEY_PORT_W-1:0] out_ekey_r, out_ekey_nxt;
  logic                  out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  // Row of cells and the flags that ripple along it.
  lrbt_find_t        seen_chain [ENTRY_COUNT+1];
  lrbt_find_t        sel_a      [ENTRY_COUNT];
  logic [KEY_W-1:0]  lkey_a     [ENTRY_COUNT];
  logic [RANK_W-1:0] lrank_a    [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] lvalid_vec;
  logic [ENTRY_COUNT-1:0] tok_vec;
  logic [ENTRY_COUNT-1:0] reserved_vec;

  lrbt_find_t        any;
  lrbt_cmd_t         cmd;
  logic [RANK_W-1:0] ref_rank;
  logic [RANK_W-1:0] lhit_rank;
  logic [INDEX_W-1:0] lhit_idx, ihit_idx, lfree_idx, ifree_idx, victim_idx, flush_idx;
  logic [KEY_W-1:0]  victim_key, flush_key;
  logic              valid_after;
  logic              exec, is_access, is_bind, is_flush;
  logic              in_flush;
  logic              flush_start, flush_emit, flush_last;
  logic              take;

  assign seen_chain[0] = '0;

  genvar g;
  generate
    for (g = 0; g < ENTRY_COUNT; g++) begin : g_cell
      // Slots beyond the mask register are never reserved.
      if (g < RESERVED_SLOTS) begin : g_res
        assign reserved_vec[g] = mask_r[g];
      end else begin : g_nores
        assign reserved_vec[g] = 1'b0;
      end

      lrbt_cell #(
        .KEY_W       (KEY_W),
        .RANK_W      (RANK_W),
        .OLDEST_RANK (ENTRY_COUNT - 1)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_i      (cmd),
        .key_i      (op_key_r),
        .ref_rank_i (ref_rank),
        .reserved_i (reserved_vec[g]),
        .seen_i     (seen_chain[g]),
        .seen_o     (seen_chain[g+1]),
        .sel_o      (sel_a[g]),
        .tok_i      ((g == 0) ? flush_start : tok_vec[(g == 0) ? 0 : g - 1]),
        .tok_o      (tok_vec[g]),
        .lvalid_o   (lvalid_vec[g]),
        .lkey_o     (lkey_a[g]),
        .lrank_o    (lrank_a[g])
      );
    end
  endgenerate

  // The end of the chain tells whether any slot offered each flag.
  assign any = seen_chain[ENTRY_COUNT];

  // Turn the one-hot selections into slot numbers, ranks and keys.
  always_comb begin
    logic tok_passed;
    lhit_idx    = '0;
    ihit_idx    = '0;
    lfree_idx   = '0;
    ifree_idx   = '0;
    victim_idx  = '0;
    flush_idx   = '0;
    lhit_rank   = '0;
    victim_key  = '0;
    flush_key   = '0;
    valid_after = 1'b0;
    tok_passed  = 1'b0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (sel_a[i].lhit) begin
        lhit_idx  = lhit_idx | INDEX_W'(i);
        lhit_rank = lhit_rank | lrank_a[i];
      end
      if (sel_a[i].ihit) begin
        ihit_idx = ihit_idx | INDEX_W'(i);
      end
      if (sel_a[i].lfree) begin
        lfree_idx = lfree_idx | INDEX_W'(i);
      end
      if (sel_a[i].ifree) begin
        ifree_idx = ifree_idx | INDEX_W'(i);
      end
      if (sel_a[i].victim) begin
        victim_idx = victim_idx | INDEX_W'(i);
        victim_key = victim_key | lkey_a[i];
      end
      if (tok_vec[i] & lvalid_vec[i]) begin
        flush_idx = flush_idx | INDEX_W'(i);
        flush_key = flush_key | lkey_a[i];
      end
      // A valid slot beyond the token still has to be reported.
      if (tok_passed & lvalid_vec[i]) begin
        valid_after = 1'b1;
      end
      tok_passed = tok_passed | tok_vec[i];
    end
  end

  // Decode the word in flight into the command that every cell sees.
  always_comb begin
    exec      = (state_r == ST_EXEC);
    in_flush  = (state_r == ST_FLUSH);
    is_access = exec & (op_func_r == FUNC_ACCESS);
    is_bind   = exec & (op_func_r == FUNC_BIND);
    is_flush  = exec & (op_func_r == FUNC_FLUSH);

    // A flush of a non-empty table launches a token into the first cell; each
    // valid cell it reaches reports its key, and the last valid one ends it.
    flush_start = is_flush & (|lvalid_vec);
    flush_emit  = in_flush & (|(tok_vec & lvalid_vec));
    flush_last  = flush_emit & ~valid_after;

    cmd.touch_hit    = is_access & any.lhit;
    cmd.touch_victim = is_access & ~any.lhit & ~any.ihit & ~any.lfree;
    cmd.fill_local   = is_access & ~any.lhit & ~any.ihit & any.lfree;
    cmd.fill_input   = is_bind & any.ifree;
    cmd.flush_clear  = flush_last;
    cmd.tok_run      = flush_start | (in_flush & ~flush_last);

    // On eviction the oldest entry is touched: every other valid entry ages.
    ref_rank = cmd.touch_hit ? lhit_rank : OLDEST;
  end

  assign take      = start & (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    op_func_nxt = op_func_r;
    op_key_nxt  = op_key_r;
    mask_nxt    = mask_r;
    if (cfg_valid & cfg_ready) begin
      mask_nxt = cfg_data;
    end
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          op_func_nxt = in_func;
          op_key_nxt  = in_key[KEY_W-1:0];
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = flush_start ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (flush_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result word of the current cycle, presented from the output registers in the next cycle.
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_class_nxt  = CLASS_NONE;
    out_index_nxt  = '0;
    out_hit_nxt    = 1'b0;
    out_ev_nxt     = 1'b0;
    out_ekey_nxt   = '0;
    out_status_nxt = STATUS_OK;
    out_last_nxt   = 1'b1;
    if (exec & ~flush_start) begin
      out_valid_nxt = 1'b1;
      if (is_access) begin
        out_class_nxt = CLASS_LOCAL;
        if (any.lhit) begin
          out_index_nxt = lhit_idx;
          out_hit_nxt   = 1'b1;
        end else if (any.ihit) begin
          out_class_nxt = CLASS_INPUT;
          out_index_nxt = ihit_idx;
          out_hit_nxt   = 1'b1;
        end else if (any.lfree) begin
          out_index_nxt = lfree_idx;
        end else begin
          out_index_nxt = victim_idx;
          out_ev_nxt    = 1'b1;
          out_ekey_nxt  = KEY_PORT_W'(victim_key);
        end
      end else if (is_bind) begin
        if (any.ifree) begin
          out_class_nxt = CLASS_INPUT;
          out_index_nxt = ifree_idx;
        end else begin
          out_status_nxt = STATUS_FULL;
        end
      end
    end else if (flush_emit) begin
      out_valid_nxt = 1'b1;
      out_class_nxt = CLASS_LOCAL;
      out_index_nxt = flush_idx;
      out_ev_nxt    = 1'b1;
      out_ekey_nxt  = KEY_PORT_W'(flush_key);
      out_last_nxt  = flush_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= RESERVED_MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_func_r    <= op_func_nxt;
    op_key_r     <= op_key_nxt;
    out_class_r  <= out_class_nxt;
    out_index_r  <= out_index_nxt;
    out_hit_r    <= out_hit_nxt;
    out_ev_r     <= out_ev_nxt;
    out_ekey_r   <= out_ekey_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reg_class   = out_class_r;
  assign out_reg_index   = out_index_r;
  assign out_hit         = out_hit_r;
  assign out_evict_valid = out_ev_r;
  assign out_evict_key   = out_ekey_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // The flush token is never in more than one cell.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("flush token held by more than one cell");

  // While flushing, the token is always somewhere in the row.
  a_token_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> $onehot(tok_vec))
    else $error("flush in progress without a token");

  // A newly taken word never has a result strobed in the very next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobed too early after a word was taken");

  // A hit never displaces an entry.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evict_valid)
    else $error("hit reported together with an eviction");
`endif

endmodule

>>> tb/sv/lru_register_binding_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LRU register binding table core.
module lru_register_binding_table_core_tb;
  import lrbt_pkg::*;

  // The block has eight slots in each table.
  localparam int SLOTS = 8;
  // Cycles allowed after the final result word for any stray strobe to show up.
  localparam int SETTLE_CYCLES = 16;
  // The package names three function codes; the fourth one is unused by the design.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One result word as the block presents it.
  typedef struct packed {
    logic [CLASS_W-1:0]    reg_class;
    logic [INDEX_W-1:0]    reg_index;
    logic                  hit;
    logic                  evict_valid;
    logic [KEY_PORT_W-1:0] evict_key;
    logic                  status;
    logic                  last;
  } binding_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     in_func;
  logic [KEY_PORT_W-1:0] in_key;
  logic                  out_valid;
  logic [CLASS_W-1:0]    out_reg_class;
  logic [INDEX_W-1:0]    out_reg_index;
  logic                  out_hit;
  logic                  out_evict_valid;
  logic [KEY_PORT_W-1:0] out_evict_key;
  logic                  out_status;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  // Shadow copy of the tables, kept in step with every word the block accepts.
  logic [KEY_PORT_W-1:0] local_tag [SLOTS];
  bit                    local_live [SLOTS];
  int                    local_age [SLOTS];
  logic [KEY_PORT_W-1:0] input_tag [SLOTS];
  bit                    input_live [SLOTS];
  logic [CFG_W-1:0]      reserved_mask;

  // Result words still owed by the block, oldest first.
  binding_t              pending_bindings [$];
  int                    error_count;
  // Chance, in percent, that the sender holds start low for another cycle.
  int                    idle_percent;
  // Keys reused by the random traffic, so that hits and evictions both happen.
  logic [KEY_PORT_W-1:0] key_pool [16];

  lru_register_binding_table_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_reg_class   (out_reg_class),
    .out_reg_index   (out_reg_index),
    .out_hit         (out_hit),
    .out_evict_valid (out_evict_valid),
    .out_evict_key   (out_evict_key),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard stop well beyond the slowest correct run, in case a handshake never completes.
  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic binding_t make_binding(input logic [CLASS_W-1:0] reg_class,
                                            input int slot, input logic hit,
                                            input logic evict_valid,
                                            input logic [KEY_PORT_W-1:0] evict_key,
                                            input logic status, input logic last);
    binding_t b;
    b.reg_class   = reg_class;
    b.reg_index   = INDEX_W'(slot);
    b.hit         = hit;
    b.evict_valid = evict_valid;
    b.evict_key   = evict_key;
    b.status      = status;
    b.last        = last;
    return b;
  endfunction

  // Makes a local entry the most recent one; entries that were younger age by one.
  function automatic void promote_local(input int slot);
    int age;
    age = local_age[slot];
    for (int j = 0; j < SLOTS; j++) begin
      if (j != slot && local_live[j] && local_age[j] < age) local_age[j]++;
    end
    local_age[slot] = 0;
  endfunction

  // An access searches the local table, then the unreserved input slots, and
  // otherwise allocates a local slot, evicting the oldest entry if none is free.
  function automatic void predict_access(input logic [KEY_PORT_W-1:0] key);
    int victim;
    victim = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (local_live[i] && local_tag[i] == key) begin
        promote_local(i);
        pending_bindings.push_back(make_binding(CLASS_LOCAL, i, 1'b1, 1'b0, '0, STATUS_OK, 1'b1));
        return;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (input_live[i] && !reserved_mask[i] && input_tag[i] == key) begin
        pending_bindings.push_back(make_binding(CLASS_INPUT, i, 1'b1, 1'b0, '0, STATUS_OK, 1'b1));
        return;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!local_live[i]) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (local_live[j]) local_age[j]++;
        end
        local_tag[i]  = key;
        local_live[i] = 1'b1;
        local_age[i]  = 0;
        pending_bindings.push_back(make_binding(CLASS_LOCAL, i, 1'b0, 1'b0, '0, STATUS_OK, 1'b1));
        return;
      end
    end
    // Table full: the oldest entry goes, the lowest index winning a tie.
    for (int i = 0; i < SLOTS; i++) begin
      if (victim < 0 || local_age[i] > local_age[victim]) victim = i;
    end
    pending_bindings.push_back(make_binding(CLASS_LOCAL, victim, 1'b0, 1'b1,
                                            local_tag[victim], STATUS_OK, 1'b1));
    local_tag[victim] = key;
    promote_local(victim);
  endfunction

  // A bind takes the first input slot that is neither bound nor reserved.
  function automatic void predict_bind(input logic [KEY_PORT_W-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (!input_live[i] && !reserved_mask[i]) begin
        input_tag[i]  = key;
        input_live[i] = 1'b1;
        pending_bindings.push_back(make_binding(CLASS_INPUT, i, 1'b0, 1'b0, '0, STATUS_OK, 1'b1));
        return;
      end
    end
    pending_bindings.push_back(make_binding(CLASS_NONE, 0, 1'b0, 1'b0, '0, STATUS_FULL, 1'b1));
  endfunction

  // A flush writes back every live local entry in slot order and clears all ranks.
  function automatic void predict_flush();
    int total;
    int n;
    total = 0;
    n     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (local_live[i]) total++;
    end
    if (total == 0) begin
      pending_bindings.push_back(make_binding(CLASS_NONE, 0, 1'b0, 1'b0, '0, STATUS_OK, 1'b1));
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (local_live[i]) begin
        n++;
        pending_bindings.push_back(make_binding(CLASS_LOCAL, i, 1'b0, 1'b1, local_tag[i],
                                                STATUS_OK, n == total));
        local_live[i] = 1'b0;
      end
      local_age[i] = 0;
    end
  endfunction

  function automatic void predict_word(input logic [FUNC_W-1:0] func,
                                       input logic [KEY_PORT_W-1:0] key);
    case (func)
      FUNC_ACCESS: predict_access(key);
      FUNC_BIND:   predict_bind(key);
      FUNC_FLUSH:  predict_flush();
      default: begin
        // The unused code answers like a flush of an empty table and changes nothing.
        pending_bindings.push_back(make_binding(CLASS_NONE, 0, 1'b0, 1'b0, '0, STATUS_OK, 1'b1));
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result words cannot be held off, so every strobe is checked at the edge that
  // ends it. Sampling right after the edge sees the values from before it.
  always @(posedge clk) begin : result_check
    binding_t want;
    if (rst_n && out_valid) begin
      if (pending_bindings.size() == 0) begin
        $error("result word with no word expected: class %0h index %0h key %0h",
               out_reg_class, out_reg_index, out_evict_key);
        error_count++;
      end else begin
        want = pending_bindings.pop_front();
        check_field("reg_class", want.reg_class, out_reg_class);
        check_field("reg_index", want.reg_index, out_reg_index);
        check_field("hit", want.hit, out_hit);
        check_field("evict_valid", want.evict_valid, out_evict_valid);
        check_field("evict_key", want.evict_key, out_evict_key);
        check_field("status", want.status, out_status);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Offers one word, after a random gap, and predicts its results once it is taken.
  // Start is left high afterwards so that back-to-back words need no second
  // assignment to start within the same time step; every caller either sends the
  // next word or lowers start before time moves on.
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [KEY_PORT_W-1:0] key);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_percent) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_func <= func;
    in_key  <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(func, key);
  endtask

  // Lowers start and waits until every owed result word has come and the block is idle.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_bindings.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The mask is only changed while the block is idle.
  task automatic write_mask(input logic [CFG_W-1:0] mask);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    reserved_mask = mask;
  endtask

  // Local table from empty: empty flush, the unused code, fills, a hit, an
  // eviction of the oldest entry and a full flush.
  task automatic test_local_table();
    idle_percent = 0;
    send_word(FUNC_FLUSH, 16'h0000);
    send_word(FUNC_UNUSED, 16'hFFFF);
    send_word(FUNC_ACCESS, 16'h0000);
    send_word(FUNC_ACCESS, 16'hFFFF);
    send_word(FUNC_ACCESS, 16'h0000);
    send_word(FUNC_ACCESS, 16'h1234);
    send_word(FUNC_ACCESS, 16'h2345);
    send_word(FUNC_ACCESS, 16'h3456);
    send_word(FUNC_ACCESS, 16'h4567);
    send_word(FUNC_ACCESS, 16'h5678);
    send_word(FUNC_ACCESS, 16'h6789);
    // The table is full now and key FFFF is the oldest entry.
    send_word(FUNC_ACCESS, 16'hA5A5);
    send_word(FUNC_FLUSH, 16'hFFFF);
  endtask

  // Input table under the reset mask: the six free slots fill, then the table is
  // full; accesses that match a bound key hit the input table.
  task automatic test_input_table();
    idle_percent = 10;
    for (int i = 0; i < 6; i++) send_word(FUNC_BIND, 16'h8000 + 16'(i));
    send_word(FUNC_BIND, 16'h7FFF);
    send_word(FUNC_ACCESS, 16'h8003);
    send_word(FUNC_ACCESS, 16'h8000);
  endtask

  // Mask extremes: with no reserved slots the last two slots bind, and with all
  // slots reserved nothing matches and every bind reports a full table.
  task automatic test_mask_extremes();
    idle_percent = 0;
    write_mask(8'h00);
    send_word(FUNC_BIND, 16'hC006);
    send_word(FUNC_BIND, 16'hC007);
    send_word(FUNC_BIND, 16'hC008);
    send_word(FUNC_ACCESS, 16'hC007);
    write_mask(8'hFF);
    send_word(FUNC_ACCESS, 16'h8003);
    send_word(FUNC_BIND, 16'h1111);
  endtask

  // Random traffic, mostly accesses to a small pool of keys so that hits, fills
  // and evictions all occur, with binds, flushes, wide keys and the unused code mixed in.
  task automatic test_random_traffic(input logic [CFG_W-1:0] mask, input int percent,
                                     input int words);
    int roll;
    write_mask(mask);
    idle_percent = percent;
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_word(FUNC_ACCESS, key_pool[$urandom_range(15)]);
      end else if (roll < 80) begin
        send_word(FUNC_ACCESS, KEY_PORT_W'($urandom()));
      end else if (roll < 88) begin
        send_word(FUNC_BIND, roll[0] ? key_pool[$urandom_range(15)] : KEY_PORT_W'($urandom()));
      end else if (roll < 96) begin
        send_word(FUNC_FLUSH, KEY_PORT_W'($urandom()));
      end else begin
        send_word(FUNC_UNUSED, KEY_PORT_W'($urandom()));
      end
    end
  endtask

  initial begin
    start         <= 1'b0;
    in_func       <= FUNC_ACCESS;
    in_key        <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    error_count   = 0;
    idle_percent  = 0;
    reserved_mask = RESERVED_MASK_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      local_tag[i]  = '0;
      local_live[i] = 1'b0;
      local_age[i]  = 0;
      input_tag[i]  = '0;
      input_live[i] = 1'b0;
    end
    for (int i = 0; i < 16; i++) key_pool[i] = KEY_PORT_W'($urandom());
    // Keep a few keys that are bound in the input table, so random accesses hit there too.
    key_pool[13] = 16'h8001;
    key_pool[14] = 16'h8005;
    key_pool[15] = 16'hC007;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_local_table();
    test_input_table();
    test_mask_extremes();
    test_random_traffic(8'h00, 0, 65);
    test_random_traffic(8'hFF, 79, 65);
    test_random_traffic(CFG_W'($urandom_range(255)), 0, 65);
    test_random_traffic(RESERVED_MASK_RESET, 10, 65);

    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> lru_register_binding_table_core.f
rtl/core/lrbt_pkg.sv
rtl/core/lrbt_cell.sv
rtl/core/lru_register_binding_table_core.sv
tb/sv/lru_register_binding_table_core_tb.sv
